// ===== rtl/core/v0ims_pkg.sv =====
// Shared types, constants and helpers for the V0 invariant mass selector.
// Used by the controller, the datapath and the top level; no dependencies.
package v0ims_pkg;

  // Particles taken into one event before further ones are ignored.
  localparam int MAX_PARTICLES = 64;

  // Configuration register indexes.
  localparam logic [2:0] CFG_WINDOW_LOW     = 3'd0;
  localparam logic [2:0] CFG_WINDOW_HIGH    = 3'd1;
  localparam logic [2:0] CFG_LIGHT_MASS     = 3'd2;
  localparam logic [2:0] CFG_HEAVY_MASS     = 3'd3;
  localparam logic [2:0] CFG_KAON_NOMINAL   = 3'd4;
  localparam logic [2:0] CFG_LAMBDA_NOMINAL = 3'd5;

  // Configuration reset values, Q16 GeV.
  localparam logic [23:0] RST_WINDOW_LOW     = 24'd32113;
  localparam logic [23:0] RST_WINDOW_HIGH    = 24'd33096;
  localparam logic [23:0] RST_LIGHT_MASS     = 24'd9147;
  localparam logic [23:0] RST_HEAVY_MASS     = 24'd61491;
  localparam logic [23:0] RST_KAON_NOMINAL   = 24'd32612;
  localparam logic [23:0] RST_LAMBDA_NOMINAL = 24'd73117;

  // Squarer operand selects.
  localparam logic [3:0] SQ_AX     = 4'd0;
  localparam logic [3:0] SQ_AY     = 4'd1;
  localparam logic [3:0] SQ_AZ     = 4'd2;
  localparam logic [3:0] SQ_LIGHT  = 4'd3;
  localparam logic [3:0] SQ_HEAVY  = 4'd4;
  localparam logic [3:0] SQ_SX     = 4'd5;
  localparam logic [3:0] SQ_SY     = 4'd6;
  localparam logic [3:0] SQ_SZ     = 4'd7;
  localparam logic [3:0] SQ_EKAON  = 4'd8;
  localparam logic [3:0] SQ_ELAM   = 4'd9;
  localparam logic [3:0] SQ_MASS   = 4'd10;

  // Momentum-square accumulator operations.
  localparam logic [1:0] P2_HOLD = 2'd0;
  localparam logic [1:0] P2_LOAD = 2'd1;
  localparam logic [1:0] P2_ADD  = 2'd2;

  // Square root radicand operations.
  localparam logic [1:0] RAD_HOLD = 2'd0;
  localparam logic [1:0] RAD_ADD  = 2'd1;
  localparam logic [1:0] RAD_SUB  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_in;
    logic       sq_en;
    logic [3:0] sq_sel;
    logic [1:0] p2_op;
    logic [1:0] rad_op;
    logic       sqrt_start;
    logic       cap_light;
    logic       cap_kaon;
    logic       upd_part;
    logic       sel_mass;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sqrt_busy;
    logic part_en;
    logic is_pos;
    logic is_last;
    logic out_free;
  } sts_t;

  // Magnitude of a signed 24-bit momentum.
  function automatic logic [23:0] mag24(input logic signed [23:0] v);
    logic [23:0] r;
    r = v[23] ? 24'(-v) : 24'(v);
    return r;
  endfunction

  // Magnitude of a signed 31-bit momentum sum.
  function automatic logic [30:0] mag31(input logic signed [30:0] v);
    logic [30:0] r;
    r = v[30] ? 31'(-v) : 31'(v);
    return r;
  endfunction

endpackage

// ===== rtl/core/v0ims_sqrt.sv =====
// Bit-serial integer square root: floor(sqrt) of a 64-bit value, one root bit per cycle.
// Depends on nothing.
module v0ims_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [63:0] rad_r, rad_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  // One restoring step: bring down two bits, try to subtract 4*root+1.
  always_comb begin
    rem_sh   = {rem_r, rad_r[63:62]};
    trial    = {1'b0, root_r, 2'b01};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rad_nxt  = radicand;
      rem_nxt  = 33'd0;
      root_nxt = 32'd0;
    end else if (busy_r) begin
      rad_nxt = {rad_r[61:0], 2'b00};
      cnt_nxt = cnt_r + 5'd1;
      if (rem_sh >= trial) begin
        rem_nxt  = 33'(rem_sh - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[32:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

// ===== rtl/core/v0ims_ctrl.sv =====
// Sequencing state machine for the V0 invariant mass selector.
// Depends on v0ims_pkg; drives v0ims_dp through cmd_t and reads sts_t.
module v0ims_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  v0ims_pkg::sts_t   sts,
  output v0ims_pkg::cmd_t   cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_P_MX   = 5'd1;
  localparam logic [4:0] ST_P_MY   = 5'd2;
  localparam logic [4:0] ST_P_MZ   = 5'd3;
  localparam logic [4:0] ST_P_ML   = 5'd4;
  localparam logic [4:0] ST_P_RADL = 5'd5;
  localparam logic [4:0] ST_P_SQL  = 5'd6;
  localparam logic [4:0] ST_P_WL   = 5'd7;
  localparam logic [4:0] ST_P_MH   = 5'd8;
  localparam logic [4:0] ST_P_RADH = 5'd9;
  localparam logic [4:0] ST_P_SQH  = 5'd10;
  localparam logic [4:0] ST_P_WH   = 5'd11;
  localparam logic [4:0] ST_P_UPD  = 5'd12;
  localparam logic [4:0] ST_E_MX   = 5'd13;
  localparam logic [4:0] ST_E_MY   = 5'd14;
  localparam logic [4:0] ST_E_MZ   = 5'd15;
  localparam logic [4:0] ST_E_MK   = 5'd16;
  localparam logic [4:0] ST_E_RADK = 5'd17;
  localparam logic [4:0] ST_E_SQK  = 5'd18;
  localparam logic [4:0] ST_E_WK   = 5'd19;
  localparam logic [4:0] ST_E_ML   = 5'd20;
  localparam logic [4:0] ST_E_RADL = 5'd21;
  localparam logic [4:0] ST_E_SQL  = 5'd22;
  localparam logic [4:0] ST_E_WL   = 5'd23;
  localparam logic [4:0] ST_E_SEL  = 5'd24;
  localparam logic [4:0] ST_E_MSQ  = 5'd25;
  localparam logic [4:0] ST_E_OUT  = 5'd26;

  logic [4:0] state_r, state_nxt;
  logic       take;

  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && !in_stall;

  // Next state and the command issued in each state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.take_in = take;
        if (take) begin
          state_nxt = ST_P_MX;
        end
      end
      ST_P_MX: begin
        // Decide here, from the counts before this particle.
        if (sts.part_en) begin
          cmd.sq_en  = 1'b1;
          cmd.sq_sel = v0ims_pkg::SQ_AX;
          state_nxt  = ST_P_MY;
        end else if (sts.is_last) begin
          state_nxt = ST_E_MX;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_P_MY: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_AY;
        cmd.p2_op = v0ims_pkg::P2_LOAD;
        state_nxt = ST_P_MZ;
      end
      ST_P_MZ: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_AZ;
        cmd.p2_op = v0ims_pkg::P2_ADD;
        state_nxt = ST_P_ML;
      end
      ST_P_ML: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_LIGHT;
        cmd.p2_op = v0ims_pkg::P2_ADD;
        state_nxt = ST_P_RADL;
      end
      ST_P_RADL: begin
        cmd.rad_op = v0ims_pkg::RAD_ADD;
        state_nxt  = ST_P_SQL;
      end
      ST_P_SQL: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_P_WL;
      end
      ST_P_WL: begin
        if (!sts.sqrt_busy) begin
          cmd.cap_light = 1'b1;
          state_nxt     = sts.is_pos ? ST_P_MH : ST_P_UPD;
        end
      end
      ST_P_MH: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_HEAVY;
        state_nxt = ST_P_RADH;
      end
      ST_P_RADH: begin
        cmd.rad_op = v0ims_pkg::RAD_ADD;
        state_nxt  = ST_P_SQH;
      end
      ST_P_SQH: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_P_WH;
      end
      ST_P_WH: begin
        if (!sts.sqrt_busy) begin
          state_nxt = ST_P_UPD;
        end
      end
      ST_P_UPD: begin
        cmd.upd_part = 1'b1;
        state_nxt    = sts.is_last ? ST_E_MX : ST_IDLE;
      end
      ST_E_MX: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_SX;
        state_nxt = ST_E_MY;
      end
      ST_E_MY: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_SY;
        cmd.p2_op = v0ims_pkg::P2_LOAD;
        state_nxt = ST_E_MZ;
      end
      ST_E_MZ: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_SZ;
        cmd.p2_op = v0ims_pkg::P2_ADD;
        state_nxt = ST_E_MK;
      end
      ST_E_MK: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_EKAON;
        cmd.p2_op = v0ims_pkg::P2_ADD;
        state_nxt = ST_E_RADK;
      end
      ST_E_RADK: begin
        cmd.rad_op = v0ims_pkg::RAD_SUB;
        state_nxt  = ST_E_SQK;
      end
      ST_E_SQK: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_E_WK;
      end
      ST_E_WK: begin
        if (!sts.sqrt_busy) begin
          cmd.cap_kaon = 1'b1;
          state_nxt    = ST_E_ML;
        end
      end
      ST_E_ML: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_ELAM;
        state_nxt = ST_E_RADL;
      end
      ST_E_RADL: begin
        cmd.rad_op = v0ims_pkg::RAD_SUB;
        state_nxt  = ST_E_SQL;
      end
      ST_E_SQL: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = ST_E_WL;
      end
      ST_E_WL: begin
        if (!sts.sqrt_busy) begin
          state_nxt = ST_E_SEL;
        end
      end
      ST_E_SEL: begin
        cmd.sel_mass = 1'b1;
        state_nxt    = ST_E_MSQ;
      end
      ST_E_MSQ: begin
        cmd.sq_en = 1'b1;
        cmd.sq_sel = v0ims_pkg::SQ_MASS;
        state_nxt = ST_E_OUT;
      end
      ST_E_OUT: begin
        // Hold until the output register can take the result.
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/v0ims_dp.sv =====
// Datapath of the V0 invariant mass selector: configuration, event sums,
// shared squarer, square root unit and output register. Depends on v0ims_pkg, v0ims_sqrt.
module v0ims_dp #(
  parameter int MAX_PARTICLES = v0ims_pkg::MAX_PARTICLES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  v0ims_pkg::cmd_t     cmd,
  output v0ims_pkg::sts_t     sts,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data,
  input  logic                in_is_positive,
  input  logic signed [23:0]  in_mom_x,
  input  logic signed [23:0]  in_mom_y,
  input  logic signed [23:0]  in_mom_z,
  input  logic                in_last_particle,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [23:0]         out_event_mass,
  output logic                out_pair_ok,
  output logic                out_in_window,
  output logic [31:0]         out_accepted_count,
  output logic [47:0]         out_mass_total,
  output logic [63:0]         out_mass_square_total
);

  // Configuration registers.
  logic [23:0] win_lo_r, win_hi_r, light_r, heavy_r, knom_r, lnom_r;

  // Latched particle.
  logic               pos_r, last_r;
  logic signed [23:0] px_r, py_r, pz_r;

  // Per-event state.
  logic [6:0]         pcnt_r, ncnt_r;
  logic signed [30:0] sx_r, sy_r, sz_r;
  logic [31:0]        ek_r, el_r;

  // Working registers.
  logic [63:0] prod_r, p2_r, rad_r;
  logic [31:0] elight_r, mk_r;
  logic [23:0] m_r;
  logic        pair_r, win_r;

  // Running totals.
  logic [31:0] acc_cnt_r;
  logic [47:0] mtot_r;
  logic [63:0] sqtot_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] o_mass_r;
  logic        o_pair_r, o_win_r;
  logic [31:0] o_cnt_r;
  logic [47:0] o_mtot_r;
  logic [63:0] o_sqtot_r;

  logic        sqrt_busy;
  logic [31:0] root;
  logic [7:0]  cnt_sum;
  logic [31:0] sq_op;
  logic [63:0] sq_res;
  logic        out_free;

  v0ims_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (rad_r),
    .busy     (sqrt_busy),
    .root     (root)
  );

  // Status toward the controller.
  assign cnt_sum  = {1'b0, pcnt_r} + {1'b0, ncnt_r};
  assign out_free = !out_valid_r || !out_stall;
  always_comb begin
    sts.sqrt_busy = sqrt_busy;
    sts.part_en   = (32'(cnt_sum) < 32'(MAX_PARTICLES));
    sts.is_pos    = pos_r;
    sts.is_last   = last_r;
    sts.out_free  = out_free;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_lo_r <= v0ims_pkg::RST_WINDOW_LOW;
      win_hi_r <= v0ims_pkg::RST_WINDOW_HIGH;
      light_r  <= v0ims_pkg::RST_LIGHT_MASS;
      heavy_r  <= v0ims_pkg::RST_HEAVY_MASS;
      knom_r   <= v0ims_pkg::RST_KAON_NOMINAL;
      lnom_r   <= v0ims_pkg::RST_LAMBDA_NOMINAL;
    end else if (cfg_valid) begin
      case (cfg_index)
        v0ims_pkg::CFG_WINDOW_LOW:     win_lo_r <= cfg_data;
        v0ims_pkg::CFG_WINDOW_HIGH:    win_hi_r <= cfg_data;
        v0ims_pkg::CFG_LIGHT_MASS:     light_r  <= cfg_data;
        v0ims_pkg::CFG_HEAVY_MASS:     heavy_r  <= cfg_data;
        v0ims_pkg::CFG_KAON_NOMINAL:   knom_r   <= cfg_data;
        v0ims_pkg::CFG_LAMBDA_NOMINAL: lnom_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Shared squarer operand select; every product in this block is a square.
  always_comb begin
    case (cmd.sq_sel)
      v0ims_pkg::SQ_AX:    sq_op = 32'(v0ims_pkg::mag24(px_r));
      v0ims_pkg::SQ_AY:    sq_op = 32'(v0ims_pkg::mag24(py_r));
      v0ims_pkg::SQ_AZ:    sq_op = 32'(v0ims_pkg::mag24(pz_r));
      v0ims_pkg::SQ_LIGHT: sq_op = 32'(light_r);
      v0ims_pkg::SQ_HEAVY: sq_op = 32'(heavy_r);
      v0ims_pkg::SQ_SX:    sq_op = 32'(v0ims_pkg::mag31(sx_r));
      v0ims_pkg::SQ_SY:    sq_op = 32'(v0ims_pkg::mag31(sy_r));
      v0ims_pkg::SQ_SZ:    sq_op = 32'(v0ims_pkg::mag31(sz_r));
      v0ims_pkg::SQ_EKAON: sq_op = ek_r;
      v0ims_pkg::SQ_ELAM:  sq_op = el_r;
      v0ims_pkg::SQ_MASS:  sq_op = 32'(m_r);
      default:             sq_op = 32'd0;
    endcase
  end
  assign sq_res = {32'd0, sq_op} * {32'd0, sq_op};

  // Input latch and arithmetic working registers.
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      pos_r  <= in_is_positive;
      last_r <= in_last_particle;
      px_r   <= in_mom_x;
      py_r   <= in_mom_y;
      pz_r   <= in_mom_z;
    end
    if (cmd.sq_en) begin
      prod_r <= sq_res;
    end
    case (cmd.p2_op)
      v0ims_pkg::P2_LOAD: p2_r <= prod_r;
      v0ims_pkg::P2_ADD:  p2_r <= p2_r + prod_r;
      default: ;
    endcase
    case (cmd.rad_op)
      v0ims_pkg::RAD_ADD: rad_r <= prod_r + p2_r;
      v0ims_pkg::RAD_SUB: rad_r <= (prod_r > p2_r) ? prod_r - p2_r : 64'd0;
      default: ;
    endcase
    if (cmd.cap_light) begin
      elight_r <= root;
    end
    if (cmd.cap_kaon) begin
      mk_r <= root;
    end
  end

  // Saturating helpers for the per-event update.
  function automatic logic signed [30:0] sat31(input logic signed [30:0] a,
                                               input logic signed [23:0] b);
    logic signed [31:0] s;
    s = 32'(a) + 32'(b);
    if (s > 32'sd1073741823) begin
      return 31'sh3FFFFFFF;
    end else if (s < -32'sd1073741824) begin
      return 31'sh40000000;
    end
    return s[30:0];
  endfunction

  function automatic logic [31:0] sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Selection of the mass nearer its nominal value, pair test and window.
  logic [31:0] dk, dl, sel;
  logic [23:0] m_sat;
  logic        pair;
  always_comb begin
    dk    = (mk_r > 32'(knom_r)) ? mk_r - 32'(knom_r) : 32'(knom_r) - mk_r;
    dl    = (root > 32'(lnom_r)) ? root - 32'(lnom_r) : 32'(lnom_r) - root;
    sel   = (dk < dl) ? mk_r : root;
    pair  = (pcnt_r == 7'd1) && (ncnt_r == 7'd1);
    m_sat = (sel > 32'h00FF_FFFF) ? 24'hFF_FFFF : sel[23:0];
    if (!pair) begin
      m_sat = 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_mass) begin
      m_r    <= m_sat;
      pair_r <= pair;
      win_r  <= pair && (m_sat > win_lo_r) && (m_sat < win_hi_r);
    end
  end

  // Running totals with saturation.
  logic [31:0] acc_cnt_nxt;
  logic [48:0] mtot_sum;
  logic [47:0] mtot_nxt;
  logic [64:0] sqtot_sum;
  logic [63:0] sqtot_nxt;
  always_comb begin
    acc_cnt_nxt = (acc_cnt_r == 32'hFFFF_FFFF) ? acc_cnt_r : acc_cnt_r + 32'd1;
    mtot_sum    = {1'b0, mtot_r} + 49'(m_r);
    mtot_nxt    = mtot_sum[48] ? 48'hFFFF_FFFF_FFFF : mtot_sum[47:0];
    sqtot_sum   = {1'b0, sqtot_r} + {1'b0, prod_r};
    sqtot_nxt   = sqtot_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sqtot_sum[63:0];
  end

  // Event state and totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r    <= 7'd0;
      ncnt_r    <= 7'd0;
      sx_r      <= '0;
      sy_r      <= '0;
      sz_r      <= '0;
      ek_r      <= 32'd0;
      el_r      <= 32'd0;
      acc_cnt_r <= 32'd0;
      mtot_r    <= 48'd0;
      sqtot_r   <= 64'd0;
    end else if (cmd.upd_part) begin
      if (pos_r) begin
        if (pcnt_r != 7'd127) begin
          pcnt_r <= pcnt_r + 7'd1;
        end
        el_r <= sat32(el_r, root);
      end else begin
        if (ncnt_r != 7'd127) begin
          ncnt_r <= ncnt_r + 7'd1;
        end
        el_r <= sat32(el_r, elight_r);
      end
      ek_r <= sat32(ek_r, elight_r);
      sx_r <= sat31(sx_r, px_r);
      sy_r <= sat31(sy_r, py_r);
      sz_r <= sat31(sz_r, pz_r);
    end else if (cmd.out_load) begin
      pcnt_r <= 7'd0;
      ncnt_r <= 7'd0;
      sx_r   <= '0;
      sy_r   <= '0;
      sz_r   <= '0;
      ek_r   <= 32'd0;
      el_r   <= 32'd0;
      if (win_r) begin
        acc_cnt_r <= acc_cnt_nxt;
        mtot_r    <= mtot_nxt;
        sqtot_r   <= sqtot_nxt;
      end
    end
  end

  // Output register; a new result loads only when the old one is gone.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_mass_r  <= m_r;
      o_pair_r  <= pair_r;
      o_win_r   <= win_r;
      o_cnt_r   <= win_r ? acc_cnt_nxt : acc_cnt_r;
      o_mtot_r  <= win_r ? mtot_nxt : mtot_r;
      o_sqtot_r <= win_r ? sqtot_nxt : sqtot_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_event_mass        = o_mass_r;
  assign out_pair_ok           = o_pair_r;
  assign out_in_window         = o_win_r;
  assign out_accepted_count    = o_cnt_r;
  assign out_mass_total        = o_mtot_r;
  assign out_mass_square_total = o_sqtot_r;

endmodule

// ===== rtl/core/v0_invariant_mass_selector.sv =====
// Top level of the V0 invariant mass selector.
// Depends on v0ims_pkg, v0ims_ctrl, v0ims_dp (and v0ims_sqrt below it).

// The block takes one particle per transfer and reconstructs a two-body
// invariant mass under the K0 and Lambda0 hypotheses at the particle marked
// last, giving one result per event with running accepted totals. Work on a
// particle is set by a single bit-serial square root unit shared by all
// energies and masses: a negative particle takes one root, a positive one
// two, and the last particle adds event-end work with two more roots.
// Particles past the per-event limit take no root. The next particle is
// accepted while a finished result still waits in the output register.
module v0_invariant_mass_selector #(
  parameter int MAX_PARTICLES = v0ims_pkg::MAX_PARTICLES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_is_positive,
  input  logic signed [23:0] in_mom_x,
  input  logic signed [23:0] in_mom_y,
  input  logic signed [23:0] in_mom_z,
  input  logic               in_last_particle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [23:0]        out_event_mass,
  output logic               out_pair_ok,
  output logic               out_in_window,
  output logic [31:0]        out_accepted_count,
  output logic [47:0]        out_mass_total,
  output logic [63:0]        out_mass_square_total
);

  v0ims_pkg::cmd_t cmd;
  v0ims_pkg::sts_t sts;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  v0ims_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  v0ims_dp #(
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_valid             (cfg_valid),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_is_positive        (in_is_positive),
    .in_mom_x              (in_mom_x),
    .in_mom_y              (in_mom_y),
    .in_mom_z              (in_mom_z),
    .in_last_particle      (in_last_particle),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_event_mass        (out_event_mass),
    .out_pair_ok           (out_pair_ok),
    .out_in_window         (out_in_window),
    .out_accepted_count    (out_accepted_count),
    .out_mass_total        (out_mass_total),
    .out_mass_square_total (out_mass_square_total)
  );

  // An accepted particle keeps the input side busy in the next cycle.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  // The root unit is never restarted while it is working.
  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sqrt_start |-> !sts.sqrt_busy)
    else $error("square root restarted while busy");

  // A result is loaded only while the output register is free.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");

  // An event in the window always passed the pair test.
  a_win_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_in_window || out_pair_ok))
    else $error("window accept without a valid pair");

endmodule
